### hdl/apl_pkg.sv
package apl_pkg;

	localparam int unsigned SampleWidth = 10;
	localparam int unsigned CountWidth  = 16;
	localparam int unsigned CfgWidth    = 16;

	// request codes carried on req_type
	typedef enum logic [1:0] {
		REQ_SAMPLE   = 2'd0,
		REQ_EXTEND   = 2'd1,
		REQ_CONTRACT = 2'd2,
		REQ_STOP     = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		MOTION_STOP     = 2'd0,
		MOTION_EXTEND   = 2'd1,
		MOTION_CONTRACT = 2'd2
	} motion_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_USE_ENCODER     = 2'd0,
		CFG_MAX_EDGE_COUNT  = 2'd1,
		CFG_LEVEL_THRESHOLD = 2'd2,
		CFG_STALL_LIMIT     = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic                   use_encoder;
		logic [CountWidth-1:0]  max_edge_count;
		logic [SampleWidth-1:0] level_threshold;
		logic [CountWidth-1:0]  stall_limit;
	} cfg_t;

	typedef struct packed {
		motion_t               motion;
		logic [CountWidth-1:0] edge_count;
		logic                  last_level;
		logic [CountWidth-1:0] idle_run;
	} track_t;

	typedef struct packed {
		logic                  drive_extend;
		logic                  drive_contract;
		logic                  accepted;
		logic [CountWidth-1:0] position;
	} res_t;

	localparam cfg_t CfgReset = '{
		use_encoder:     1'b1,
		max_edge_count:  16'd1000,
		level_threshold: 10'd512,
		stall_limit:     16'd100
	};

	localparam track_t TrackReset = '{
		motion:     MOTION_STOP,
		edge_count: '0,
		last_level: 1'b0,
		idle_run:   '0
	};

endpackage

### hdl/apl_update.sv
module apl_update
	import apl_pkg::*;
(
	input  cfg_t                   cfg,
	input  track_t                 cur,
	input  logic [1:0]             req_type,
	input  logic [SampleWidth-1:0] sample,
	output track_t                 nxt,
	output res_t                   res
);

	logic level;
	logic step;
	logic below_max;
	logic above_zero;
	logic ok;

	assign level      = (sample > cfg.level_threshold);
	assign step       = (level != cur.last_level) || (cur.idle_run >= cfg.stall_limit);
	assign below_max  = (cur.edge_count < cfg.max_edge_count);
	assign above_zero = (cur.edge_count != '0);

	always_comb begin
		nxt = cur;
		ok  = 1'b1;
		case (req_t'(req_type))
			REQ_SAMPLE: begin
				if (cfg.use_encoder) begin
					if (step) begin
						if (cur.motion == MOTION_EXTEND && below_max) begin
							nxt.edge_count = cur.edge_count + 1'b1;
						end else if (cur.motion == MOTION_CONTRACT && above_zero) begin
							nxt.edge_count = cur.edge_count - 1'b1;
						end
						nxt.idle_run = '0;
					end else if (cur.idle_run != '1) begin
						nxt.idle_run = cur.idle_run + 1'b1;
					end
					nxt.last_level = level;
				end
			end
			REQ_EXTEND: begin
				if (!cfg.use_encoder || below_max) begin
					nxt.motion = MOTION_EXTEND;
				end else begin
					ok = 1'b0;
				end
			end
			REQ_CONTRACT: begin
				if (!cfg.use_encoder || above_zero) begin
					nxt.motion = MOTION_CONTRACT;
				end else begin
					ok = 1'b0;
				end
			end
			REQ_STOP: begin
				nxt.motion = MOTION_STOP;
			end
			default: begin
				nxt.motion = MOTION_STOP;
			end
		endcase
	end

	always_comb begin
		res.drive_extend   = (nxt.motion == MOTION_EXTEND);
		res.drive_contract = (nxt.motion == MOTION_CONTRACT);
		res.accepted       = ok;
		res.position       = nxt.edge_count;
	end

endmodule

### hdl/actuator_position_limiter_unit.sv
// channel | signals                              | carries
// in      | in_valid, in_ready, req_type, sample | request or encoder sample transfer
// out     | out_valid, out_ready, drive_extend,  | one result transfer per request
//         | drive_contract, accepted, position   |
// cfg     | cfg_we, cfg_index, cfg_data          | register write, no handshake
//
// two register stages: an input register (_s1) and a result register (_s2)
// one item per cycle sustained while out_ready stays high; an item passes _s1, then _s2, which drives out_valid
// tracking state updates as an item moves from _s1 to _s2, so back to back
// items see each other's effect with no bubble
// a stall on out holds both stages; in_ready drops only when both are full
// arst_n clears valids, tracking state and configuration registers to their reset values
module actuator_position_limiter_unit
	import apl_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             req_type,
	input  logic [SampleWidth-1:0] sample,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   drive_extend,
	output logic                   drive_contract,
	output logic                   accepted,
	output logic [CountWidth-1:0]  position,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [CfgWidth-1:0]    cfg_data
);

	cfg_t   cfg_q;
	track_t track_q;
	track_t track_nxt;
	res_t   res_nxt;
	res_t   res_s2;

	logic                   valid_s1;
	logic [1:0]             req_s1;
	logic [SampleWidth-1:0] sample_s1;
	logic                   valid_s2;
	logic                   adv_s2;

	// result stage takes a new item when empty or being drained
	assign adv_s2   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CfgReset;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_USE_ENCODER:     cfg_q.use_encoder     <= cfg_data[0];
				CFG_MAX_EDGE_COUNT:  cfg_q.max_edge_count  <= cfg_data[CountWidth-1:0];
				CFG_LEVEL_THRESHOLD: cfg_q.level_threshold <= cfg_data[SampleWidth-1:0];
				CFG_STALL_LIMIT:     cfg_q.stall_limit     <= cfg_data[CountWidth-1:0];
				default:             cfg_q                 <= cfg_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1    <= req_type;
			sample_s1 <= sample;
		end
	end

	apl_update u_update (
		.cfg      (cfg_q),
		.cur      (track_q),
		.req_type (req_s1),
		.sample   (sample_s1),
		.nxt      (track_nxt),
		.res      (res_nxt)
	);

	// tracking state commits as the item enters the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_q <= TrackReset;
		end else if (adv_s2) begin
			track_q <= track_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid      = valid_s2;
	assign drive_extend   = res_s2.drive_extend;
	assign drive_contract = res_s2.drive_contract;
	assign accepted       = res_s2.accepted;
	assign position       = res_s2.position;

endmodule

### tb/tb_actuator_position_limiter_unit.sv
module tb_actuator_position_limiter_unit
	import apl_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// one request as queued for the driver
	typedef struct packed {
		req_t                   req;
		logic [SampleWidth-1:0] smp;
	} request_t;

	localparam int unsigned IdlePct     = 17;
	localparam int unsigned HoldCycles  = 80;
	localparam int unsigned HoldAfter   = 150;
	localparam int unsigned StuckLimit  = 2000;
	localparam int unsigned PrintLimit  = 30;
	localparam int unsigned RandomItems = 400;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [1:0]             req_type = '0;
	logic [SampleWidth-1:0] sample = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic                   drive_extend;
	logic                   drive_contract;
	logic                   accepted;
	logic [CountWidth-1:0]  position;
	logic                   cfg_we = 1'b0;
	logic [1:0]             cfg_index = '0;
	logic [CfgWidth-1:0]    cfg_data = '0;

	// requests waiting to be offered, and results the tracker says must come back
	request_t    pending_reqs[$];
	res_t        expected_results[$];
	request_t    on_the_wire;

	// independent copy of the register file and the tracking state
	cfg_t        regs_shadow;
	track_t      tracker;

	int unsigned cycle_no = 0;
	int unsigned reqs_sent = 0;
	int unsigned results_seen = 0;
	int unsigned settings_used = 0;
	int unsigned fault_count = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;

	// calm window: no idling on either side for a stretch at the start of each period
	wire calm = (cycle_no % 3000) < 400;

	actuator_position_limiter_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.sample         (sample),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.drive_extend   (drive_extend),
		.drive_contract (drive_contract),
		.accepted       (accepted),
		.position       (position),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
	end

	task automatic note_fault(input string msg);
		fault_count++;
		if (fault_count <= PrintLimit) begin
			$display("[%0t] mismatch: %s", $realtime, msg);
		end
	endtask

	// step the tracker by one request and record the result it must produce
	task automatic track_request(input request_t r);
		logic level;
		logic ok;
		res_t want;
		ok = 1'b1;
		case (r.req)
			REQ_SAMPLE: begin
				if (regs_shadow.use_encoder) begin
					level = (r.smp > regs_shadow.level_threshold);
					if (level != tracker.last_level ||
					    tracker.idle_run >= regs_shadow.stall_limit) begin
						// a level change or a stalled run counts one edge
						if (tracker.motion == MOTION_EXTEND &&
						    tracker.edge_count < regs_shadow.max_edge_count) begin
							tracker.edge_count = tracker.edge_count + 1'b1;
						end else if (tracker.motion == MOTION_CONTRACT &&
						             tracker.edge_count != '0) begin
							tracker.edge_count = tracker.edge_count - 1'b1;
						end
						tracker.idle_run = '0;
					end else if (tracker.idle_run != '1) begin
						tracker.idle_run = tracker.idle_run + 1'b1;
					end
					tracker.last_level = level;
				end
			end
			REQ_EXTEND: begin
				if (!regs_shadow.use_encoder ||
				    tracker.edge_count < regs_shadow.max_edge_count) begin
					tracker.motion = MOTION_EXTEND;
				end else begin
					ok = 1'b0;
				end
			end
			REQ_CONTRACT: begin
				if (!regs_shadow.use_encoder || tracker.edge_count != '0) begin
					tracker.motion = MOTION_CONTRACT;
				end else begin
					ok = 1'b0;
				end
			end
			default: begin
				tracker.motion = MOTION_STOP;
			end
		endcase
		want.drive_extend   = (tracker.motion == MOTION_EXTEND);
		want.drive_contract = (tracker.motion == MOTION_CONTRACT);
		want.accepted       = ok;
		want.position       = tracker.edge_count;
		expected_results.push_back(want);
	endtask

	// driver: offers queued requests, holding each until its transfer
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				track_request(on_the_wire);
				reqs_sent++;
			end
			if (!in_valid || in_ready) begin
				if (pending_reqs.size() != 0 &&
				    (calm || $urandom_range(99) >= IdlePct)) begin
					on_the_wire = pending_reqs.pop_front();
					in_valid <= 1'b1;
					req_type <= on_the_wire.req;
					sample   <= on_the_wire.smp;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks every result transfer against the oldest expectation
	always @(posedge clk) begin
		res_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					note_fault($sformatf("result %0d arrived with nothing expected",
						results_seen));
				end else begin
					want = expected_results.pop_front();
					if (drive_extend !== want.drive_extend) begin
						note_fault($sformatf("result %0d drive_extend got %b expected %b",
							results_seen, drive_extend, want.drive_extend));
					end
					if (drive_contract !== want.drive_contract) begin
						note_fault($sformatf("result %0d drive_contract got %b expected %b",
							results_seen, drive_contract, want.drive_contract));
					end
					if (accepted !== want.accepted) begin
						note_fault($sformatf("result %0d accepted got %b expected %b",
							results_seen, accepted, want.accepted));
					end
					if (position !== want.position) begin
						note_fault($sformatf("result %0d position got %0d expected %0d",
							results_seen, position, want.position));
					end
				end
				results_seen++;
			end
			// one long hold-off so the pipeline fills and in_ready drops
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!hold_done && results_seen >= HoldAfter) begin
				hold_done = 1'b1;
				hold_left = HoldCycles - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= IdlePct);
			end
		end
	end

	// watchdog: gives up after too many cycles without any transfer
	initial begin
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < StuckLimit) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("[%0t] no transfer for %0d cycles", $realtime, StuckLimit);
		$display("TB_ERROR");
		$finish;
	end

	task automatic queue_req(input req_t req, input logic [SampleWidth-1:0] smp);
		request_t r;
		r.req = req;
		r.smp = smp;
		pending_reqs.push_back(r);
	endtask

	// mostly samples so the count keeps moving, with commands mixed in
	task automatic queue_random(input int unsigned n);
		logic [SampleWidth-1:0] smp;
		int unsigned pick;
		for (int unsigned i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			case ($urandom_range(9))
				0:       smp = '0;
				1:       smp = '1;
				default: smp = SampleWidth'($urandom_range(1023));
			endcase
			if (pick < 65) begin
				queue_req(REQ_SAMPLE, smp);
			end else if (pick < 78) begin
				queue_req(REQ_EXTEND, smp);
			end else if (pick < 91) begin
				queue_req(REQ_CONTRACT, smp);
			end else begin
				queue_req(REQ_STOP, smp);
			end
		end
	endtask

	// wait until every queued request has been answered
	task automatic drain();
		while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (3) @(posedge clk);
	endtask

	// write all four registers on consecutive cycles while the block is idle
	task automatic apply_setting(input cfg_t c);
		regs_shadow = c;
		settings_used++;
		cfg_we    <= 1'b1;
		cfg_index <= CFG_USE_ENCODER;
		cfg_data  <= CfgWidth'(c.use_encoder);
		@(posedge clk);
		cfg_index <= CFG_MAX_EDGE_COUNT;
		cfg_data  <= CfgWidth'(c.max_edge_count);
		@(posedge clk);
		cfg_index <= CFG_LEVEL_THRESHOLD;
		cfg_data  <= CfgWidth'(c.level_threshold);
		@(posedge clk);
		cfg_index <= CFG_STALL_LIMIT;
		cfg_data  <= CfgWidth'(c.stall_limit);
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		cfg_t c;
		// power-on register values and a fully contracted actuator
		regs_shadow = '{1'b1, 16'd1000, 10'd512, 16'd100};
		tracker.motion     = MOTION_STOP;
		tracker.edge_count = '0;
		tracker.last_level = 1'b0;
		tracker.idle_run   = '0;

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// directed pass on the reset settings
		queue_req(REQ_STOP, '0);
		queue_req(REQ_CONTRACT, '1);      // refused at the lower travel limit
		queue_req(REQ_SAMPLE, '0);        // same level, run grows
		queue_req(REQ_EXTEND, '0);
		queue_req(REQ_SAMPLE, 10'd513);   // just above threshold
		queue_req(REQ_SAMPLE, 10'd512);   // at threshold reads as low
		queue_req(REQ_SAMPLE, '1);
		queue_req(REQ_SAMPLE, '1);
		queue_req(REQ_CONTRACT, 10'h2aa);
		queue_req(REQ_SAMPLE, '0);
		queue_req(REQ_SAMPLE, 10'h155);
		queue_req(REQ_STOP, '1);
		queue_req(REQ_SAMPLE, '1);        // level change while stopped
		queue_req(REQ_SAMPLE, '0);
		queue_req(REQ_EXTEND, '1);
		queue_req(REQ_SAMPLE, '1);
		queue_req(REQ_STOP, 10'h155);
		queue_req(REQ_CONTRACT, '0);
		queue_req(REQ_SAMPLE, '0);
		drain();

		// stall limit zero: every sample steps, travel up to the top
		apply_setting('{1'b1, 16'hffff, 10'd0, 16'd0});
		queue_random(RandomItems / 5);
		drain();

		// threshold at the top reads always low, so past a first level change only stalls move a short travel
		apply_setting('{1'b1, 16'd5, 10'h3ff, 16'd3});
		queue_req(REQ_EXTEND, '0);
		queue_random(RandomItems / 5);
		drain();

		// push to the top, then lower the limit beneath the count
		apply_setting('{1'b1, 16'd8, 10'd300, 16'd1});
		queue_req(REQ_EXTEND, '0);
		for (int i = 0; i < 20; i++) begin
			queue_req(REQ_SAMPLE, (i % 2) ? 10'd900 : 10'd10);
		end
		drain();
		apply_setting('{1'b1, 16'd2, 10'd300, 16'd1});
		queue_req(REQ_EXTEND, '0);
		queue_req(REQ_SAMPLE, '1);
		queue_random(RandomItems / 8);
		drain();

		// encoder off: commands never refused, samples change nothing
		apply_setting('{1'b0, 16'd0, 10'd512, 16'd100});
		queue_random(RandomItems / 8);
		drain();

		// zero travel range with the encoder back on
		apply_setting('{1'b1, 16'd0, 10'd512, 16'd100});
		queue_random(RandomItems / 12);
		drain();

		// random settings, small limits mostly
		for (int p = 0; p < 3; p++) begin
			c.use_encoder     = ($urandom_range(4) != 0);
			c.max_edge_count  = CountWidth'($urandom_range(40));
			c.level_threshold = SampleWidth'($urandom_range(1023));
			c.stall_limit     = CountWidth'($urandom_range(6));
			apply_setting(c);
			queue_random(RandomItems / 10);
			drain();
		end

		// widest stall limit: an unchanged run of low samples steps only once idle_run saturates
		apply_setting('{1'b1, 16'hffff, 10'h3ff, 16'hffff});
		queue_req(REQ_EXTEND, '0);
		for (int i = 0; i < 20; i++) begin
			queue_req(REQ_SAMPLE, SampleWidth'($urandom_range(1023)));
		end
		queue_random(RandomItems / 20);
		drain();

		$display("covered %0d requests under %0d register settings, %0d results checked",
			reqs_sent, settings_used, results_seen);
		$display("including travel limits, encoder off, lowered limit and a %0d-cycle hold-off",
			HoldCycles);
		if (fault_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", fault_count);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

### files.f
hdl/apl_pkg.sv
hdl/apl_update.sv
hdl/actuator_position_limiter_unit.sv
tb/tb_actuator_position_limiter_unit.sv
